// ----- rtl/mvga_pkg.sv -----
package mvga_pkg;

    // field widths of commands, results and accumulator entries
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 32;
    localparam int COUNT_W = 16;
    localparam int GRAD_W  = 17;
    localparam int AMT_W   = VALUE_W + 1;

    localparam int NODE_COUNT_DEF = 1024;
    localparam int CORNERS        = 3;

    // command codes
    typedef enum logic [1:0] {
        MODE_WRITE    = 2'd0,
        MODE_TRIANGLE = 2'd1,
        MODE_READ     = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VAL_RD,
        ST_VAL_CAP,
        ST_DIFF,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_GRD_RD,
        ST_GRD_CAP,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        mode_t                mode;
        logic [INDEX_W-1:0]   node_index;
        logic [VALUE_W-1:0]   node_value;
        logic [INDEX_W-1:0]   corner_a;
        logic [INDEX_W-1:0]   corner_b;
        logic [INDEX_W-1:0]   corner_c;
    } cmd_t;

    typedef struct packed {
        logic [GRAD_W-1:0]    gradient_value;
        logic                 no_triangles;
        logic                 saturated;
    } res_t;

    // one accumulator entry: mark, count and sum together
    typedef struct packed {
        logic                 sat;
        logic [COUNT_W-1:0]   count;
        logic [SUM_W-1:0]     sum;
    } acc_t;

    localparam int ACC_W = $bits(acc_t);

endpackage

// ----- rtl/mvga_cmd_if.sv -----
interface mvga_cmd_if;
    import mvga_pkg::*;

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mvga_res_if.sv -----
interface mvga_res_if;
    import mvga_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mesh_vertex_gradient_average.sv -----
// channel  dir  beat contents
// -------  ---  ---------------------------------------------------------------
// cmd      in   mode, node_index, node_value, corner_a, corner_b, corner_c
// res      out  gradient_value, no_triangles, saturated (mode 2 beats only)
//
// node write: done on the accepted beat. triangle: three value reads then three
// read-modify-writes of the accumulator memory.
// gradient read: a 32-step restoring divider; the divide is skipped when
// the node has no triangles.
// clear and reset: a sweep over min(NODE_COUNT, 1024) entries of the accumulator
// memory, one entry a cycle, during which cmd.ready is low.
// a finished result sits in an output register while the next beat is taken;
// a read holds in its last cycle while that register is still full.
module mesh_vertex_gradient_average #(
    parameter int NODE_COUNT = mvga_pkg::NODE_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    mvga_cmd_if.sink           cmd,
    mvga_res_if.source         res
);
    import mvga_pkg::*;

    localparam int DEPTH    = (NODE_COUNT < (1 << INDEX_W)) ? NODE_COUNT : (1 << INDEX_W);
    localparam int AW       = $clog2(DEPTH);
    localparam int DIV_CW   = $clog2(SUM_W);
    localparam logic [1:0] LAST_CORNER = 2'(CORNERS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(SUM_W - 1);

    function automatic logic in_range(input logic [INDEX_W-1:0] idx);
        return (32'(idx) < NODE_COUNT);
    endfunction

    function automatic logic [VALUE_W-1:0] abs_diff(input logic [VALUE_W-1:0] x,
                                                    input logic [VALUE_W-1:0] y);
        return (x >= y) ? (x - y) : (y - x);
    endfunction

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [1:0]             corner_reg, corner_next;
    logic [AW-1:0]          addr_reg [CORNERS];
    logic [AW-1:0]          addr_next [CORNERS];
    logic [VALUE_W-1:0]     val_reg [CORNERS];
    logic [VALUE_W-1:0]     val_next [CORNERS];
    logic [AMT_W-1:0]       amt_reg [CORNERS];
    logic [AMT_W-1:0]       amt_next [CORNERS];
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    logic [COUNT_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CW-1:0]      step_reg, step_next;
    res_t                   pend_reg, pend_next;
    res_t                   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   cmd_accept;
    logic                   val_we;
    logic [AW-1:0]          val_raddr;
    logic [VALUE_W-1:0]     val_rdata;
    logic                   acc_we;
    logic [AW-1:0]          acc_waddr;
    logic [AW-1:0]          acc_raddr;
    acc_t                   acc_wdata;
    acc_t                   acc_rdata;
    acc_t                   acc_upd;
    logic [SUM_W:0]         sum_wide;
    logic                   count_full;
    logic [COUNT_W:0]       rem_shift;
    logic                   quo_bit;
    logic                   div_done;

    assign cmd_accept = cmd.valid && cmd.ready;
    assign div_done   = (step_reg == LAST_STEP);

    // node values and accumulators
    mvga_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (cmd.data.node_index[AW-1:0]),
        .wdata (cmd.data.node_value),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    mvga_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // saturating update of the entry just read
    always_comb
    begin
        sum_wide   = {1'b0, acc_rdata.sum} + (SUM_W + 1)'(amt_reg[corner_reg]);
        count_full = (acc_rdata.count == '1);
        acc_upd.sum   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        acc_upd.count = count_full ? acc_rdata.count : acc_rdata.count + 1'b1;
        acc_upd.sat   = acc_rdata.sat | sum_wide[SUM_W] | count_full;
    end

    // one restoring divide step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        quo_bit   = (rem_shift >= {1'b0, dvs_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.data.mode)
                        MODE_WRITE:
                        begin
                            state_next = ST_IDLE;
                        end
                        MODE_TRIANGLE:
                        begin
                            if (in_range(cmd.data.corner_a) && in_range(cmd.data.corner_b)
                                && in_range(cmd.data.corner_c))
                            begin
                                state_next = ST_VAL_RD;
                            end
                        end
                        MODE_READ:
                        begin
                            state_next = in_range(cmd.data.node_index) ? ST_GRD_RD
                                                                       : ST_FINISH;
                        end
                        MODE_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_VAL_RD:
            begin
                state_next = ST_VAL_CAP;
            end
            ST_VAL_CAP:
            begin
                state_next = (corner_reg == LAST_CORNER) ? ST_DIFF : ST_VAL_RD;
            end
            ST_DIFF:
            begin
                state_next = ST_ACC_RD;
            end
            ST_ACC_RD:
            begin
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                state_next = (corner_reg == LAST_CORNER) ? ST_IDLE : ST_ACC_RD;
            end
            ST_GRD_RD:
            begin
                state_next = ST_GRD_CAP;
            end
            ST_GRD_CAP:
            begin
                state_next = (acc_rdata.count == '0) ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake outputs
    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE);
        val_we    = cmd_accept && (cmd.data.mode == MODE_WRITE)
                    && in_range(cmd.data.node_index);
        val_raddr = addr_reg[corner_reg];
        acc_we    = 1'b0;
        acc_waddr = addr_reg[corner_reg];
        acc_raddr = addr_reg[corner_reg];
        acc_wdata = acc_upd;
        case (state_reg)
            ST_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
                acc_wdata = '0;
            end
            ST_ACC_WR:
            begin
                acc_we = 1'b1;
            end
            default:
            begin
                acc_we = 1'b0;
            end
        endcase
        res.valid = out_valid_reg;
        res.data  = out_reg;
    end

    // datapath
    always_comb
    begin
        clr_next       = clr_reg;
        corner_next    = corner_reg;
        addr_next      = addr_reg;
        val_next       = val_reg;
        amt_next       = amt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        step_next      = step_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // output register frees as soon as its beat is taken
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                corner_next = '0;
                clr_next    = '0;
                if (cmd.data.mode == MODE_READ)
                begin
                    addr_next[0] = cmd.data.node_index[AW-1:0];
                end
                else
                begin
                    addr_next[0] = cmd.data.corner_a[AW-1:0];
                end
                addr_next[1] = cmd.data.corner_b[AW-1:0];
                addr_next[2] = cmd.data.corner_c[AW-1:0];
                // out-of-range read answers at once
                pend_next.gradient_value = '0;
                pend_next.no_triangles   = 1'b1;
                pend_next.saturated      = 1'b0;
            end
            ST_VAL_CAP:
            begin
                val_next[corner_reg] = val_rdata;
                corner_next = (corner_reg == LAST_CORNER) ? 2'd0 : corner_reg + 1'b1;
            end
            ST_DIFF:
            begin
                amt_next[0] = AMT_W'(abs_diff(val_reg[0], val_reg[1]))
                              + AMT_W'(abs_diff(val_reg[0], val_reg[2]));
                amt_next[1] = AMT_W'(abs_diff(val_reg[0], val_reg[1]))
                              + AMT_W'(abs_diff(val_reg[1], val_reg[2]));
                amt_next[2] = AMT_W'(abs_diff(val_reg[0], val_reg[2]))
                              + AMT_W'(abs_diff(val_reg[1], val_reg[2]));
            end
            ST_ACC_WR:
            begin
                corner_next = (corner_reg == LAST_CORNER) ? 2'd0 : corner_reg + 1'b1;
            end
            ST_GRD_CAP:
            begin
                quo_next  = acc_rdata.sum;
                dvs_next  = acc_rdata.count;
                rem_next  = '0;
                step_next = '0;
                pend_next.gradient_value = '0;
                pend_next.no_triangles   = (acc_rdata.count == '0);
                pend_next.saturated      = acc_rdata.sat;
            end
            ST_DIV:
            begin
                rem_next  = quo_bit ? COUNT_W'(rem_shift - {1'b0, dvs_reg})
                                    : rem_shift[COUNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], quo_bit};
                step_next = step_reg + 1'b1;
                if (div_done)
                begin
                    pend_next.gradient_value = quo_next[GRAD_W-1:0];
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            corner_reg    <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            corner_reg    <= corner_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        val_reg  <= val_next;
        amt_reg  <= amt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // checks
    a_acc_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc_we |-> (state_reg == ST_CLEAR || state_reg == ST_ACC_WR))
        else $error("accumulator written outside clear or update");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.no_triangles) |-> (out_reg.gradient_value == '0))
        else $error("empty node returned nonzero gradient");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_done) |=> (state_reg == ST_FINISH))
        else $error("divider did not finish after last step");

    a_sweep_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && state_next != ST_CLEAR) |-> (clr_reg == LAST_ADDR))
        else $error("clear sweep ended early");

    a_val_write_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        val_we |-> (cmd_accept && state_reg == ST_IDLE))
        else $error("value store written without a command beat");

endmodule

// ----- rtl/mvga_ram.sv -----
module mvga_ram #(
    parameter int WIDTH = mvga_pkg::VALUE_W,
    parameter int DEPTH = mvga_pkg::NODE_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- verif/tb_mesh_vertex_gradient_average.sv -----
`timescale 1ns / 100ps

module tb_mesh_vertex_gradient_average;
    import mvga_pkg::*;

    localparam int NODES      = NODE_COUNT_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int BURST_TRIS = 64;

    typedef struct {
        cmd_t        cmd;
        bit          drain;
        int unsigned gap_max;
    } pending_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    mvga_cmd_if cmd_ch ();
    mvga_res_if res_ch ();

    mesh_vertex_gradient_average dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // mirror of the block's memories
    bit [VALUE_W-1:0] node_value_mem [NODES];
    bit [SUM_W-1:0]   diff_sum_mem   [NODES];
    bit [COUNT_W-1:0] tri_count_mem  [NODES];
    bit               sat_mark_mem   [NODES];

    pending_cmd_t cmd_pending_q[$];
    res_t         gradient_expect_q[$];

    // generator view of which nodes hold a value
    bit node_written [NODES];
    int written_list[$];

    int          cmds_queued = 0;
    int          cmds_taken  = 0;
    int          fail_count  = 0;
    int unsigned tx_gap_max  = 7;
    int unsigned rx_gap_max  = 7;
    bit          drain_next  = 1'b0;
    int unsigned send_wait;
    int unsigned take_wait;
    int          idle_cycles = 0;

    always #5 clk = ~clk;

    function automatic bit [VALUE_W-1:0] abs_gap(bit [VALUE_W-1:0] x, bit [VALUE_W-1:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

    // one corner read-modify-write, clamping sum and count
    function automatic void add_corner_share(bit [INDEX_W-1:0] node, bit [AMT_W-1:0] amount);
        bit [SUM_W:0] total;
        total = {1'b0, diff_sum_mem[node]} + (SUM_W + 1)'(amount);
        if (total[SUM_W])
        begin
            diff_sum_mem[node] = '1;
            sat_mark_mem[node] = 1'b1;
        end
        else
            diff_sum_mem[node] = total[SUM_W-1:0];
        if (tri_count_mem[node] == '1)
            sat_mark_mem[node] = 1'b1;
        else
            tri_count_mem[node] = tri_count_mem[node] + 1'b1;
    endfunction

    function automatic void predict_command(cmd_t c);
        bit [VALUE_W-1:0] va, vb, vc, dab, dac, dbc;
        bit [SUM_W-1:0]   quot;
        res_t             r;
        case (c.mode)
            MODE_WRITE:
                node_value_mem[c.node_index] = c.node_value;
            MODE_TRIANGLE:
            begin
                va  = node_value_mem[c.corner_a];
                vb  = node_value_mem[c.corner_b];
                vc  = node_value_mem[c.corner_c];
                dab = abs_gap(va, vb);
                dac = abs_gap(va, vc);
                dbc = abs_gap(vb, vc);
                add_corner_share(c.corner_a, AMT_W'(dab) + AMT_W'(dac));
                add_corner_share(c.corner_b, AMT_W'(dab) + AMT_W'(dbc));
                add_corner_share(c.corner_c, AMT_W'(dac) + AMT_W'(dbc));
            end
            MODE_READ:
            begin
                r.saturated = sat_mark_mem[c.node_index];
                if (tri_count_mem[c.node_index] == '0)
                begin
                    r.gradient_value = '0;
                    r.no_triangles   = 1'b1;
                end
                else
                begin
                    quot = diff_sum_mem[c.node_index] / tri_count_mem[c.node_index];
                    r.gradient_value = quot[GRAD_W-1:0];
                    r.no_triangles   = 1'b0;
                end
                gradient_expect_q.push_back(r);
            end
            default:
                for (int i = 0; i < NODES; i++)
                begin
                    diff_sum_mem[i]  = '0;
                    tri_count_mem[i] = '0;
                    sat_mark_mem[i]  = 1'b0;
                end
        endcase
    endfunction

    // queue one command with the current sender settings
    task automatic send(mode_t m, int n = 0, int v = 0, int a = 0, int b = 0, int c = 0);
        pending_cmd_t p;
        p.cmd.mode       = m;
        p.cmd.node_index = INDEX_W'(n);
        p.cmd.node_value = VALUE_W'(v);
        p.cmd.corner_a   = INDEX_W'(a);
        p.cmd.corner_b   = INDEX_W'(b);
        p.cmd.corner_c   = INDEX_W'(c);
        p.drain          = drain_next;
        p.gap_max        = tx_gap_max;
        drain_next       = 1'b0;
        if (m == MODE_WRITE && !node_written[n])
        begin
            node_written[n] = 1'b1;
            written_list.push_back(n);
        end
        cmd_pending_q.push_back(p);
        cmds_queued++;
    endtask

    task automatic wait_all_done();
        while (cmds_taken != cmds_queued || gradient_expect_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic int pick_node();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, NODES - 1)
                                           : $urandom_range(0, 31);
    endfunction

    function automatic int pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
            send_wait = 0;
        end
        else
        begin
            // a beat taken on this edge updates the mirror
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_command(cmd_ch.data);
                cmds_taken++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_pending_q.size() != 0 &&
                         !(cmd_pending_q[0].drain && gradient_expect_q.size() != 0))
                begin
                    cmd_ch.data  <= cmd_pending_q[0].cmd;
                    cmd_ch.valid <= 1'b1;
                    send_wait = $urandom_range(0, cmd_pending_q[0].gap_max);
                    void'(cmd_pending_q.pop_front());
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            take_wait = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (gradient_expect_q.size() == 0)
                begin
                    $error("result beat with no gradient read outstanding");
                    fail_count++;
                end
                else
                begin
                    res_t e;
                    e = gradient_expect_q.pop_front();
                    if (res_ch.data.gradient_value !== e.gradient_value)
                    begin
                        $error("gradient_value mismatch: expected %0d, actual %0d",
                               e.gradient_value, res_ch.data.gradient_value);
                        fail_count++;
                    end
                    if (res_ch.data.no_triangles !== e.no_triangles)
                    begin
                        $error("no_triangles mismatch: expected %0d, actual %0d",
                               e.no_triangles, res_ch.data.no_triangles);
                        fail_count++;
                    end
                    if (res_ch.data.saturated !== e.saturated)
                    begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               e.saturated, res_ch.data.saturated);
                        fail_count++;
                    end
                end
                take_wait = $urandom_range(0, rx_gap_max);
            end
            else if (take_wait != 0)
                take_wait--;
            res_ch.ready <= (take_wait == 0);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles with no beat", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, repeated corners, empty node, clear
        send(MODE_WRITE, 0, 16'h0000);
        send(MODE_WRITE, 1023, 16'hFFFF);
        send(MODE_WRITE, 1, 16'h8000);
        send(MODE_WRITE, 2, 16'h5555);
        send(MODE_WRITE, 3, 16'hAAAA);
        send(MODE_TRIANGLE, 0, 0, 0, 1023, 1);
        send(MODE_TRIANGLE, 0, 0, 1023, 2, 0);
        send(MODE_TRIANGLE, 0, 0, 1, 0, 1023);
        send(MODE_TRIANGLE, 0, 0, 2, 2, 1023);
        send(MODE_TRIANGLE, 0, 0, 3, 3, 3);
        send(MODE_READ, 0);
        send(MODE_READ, 1023);
        send(MODE_READ, 1);
        send(MODE_READ, 2);
        send(MODE_READ, 3);
        // node with no triangles, sent once all earlier reads are back
        drain_next = 1'b1;
        send(MODE_READ, 500);
        send(MODE_CLEAR);
        send(MODE_READ, 0);
        // largest gradient: full-scale gap on a single triangle
        send(MODE_TRIANGLE, 0, 0, 0, 0, 1023);
        send(MODE_READ, 1023);
        send(MODE_READ, 0);
        wait_all_done();

        // one full-scale triangle repeated, back to back
        tx_gap_max = 0;
        rx_gap_max = 0;
        send(MODE_CLEAR);
        for (int i = 0; i < BURST_TRIS; i++)
            send(MODE_TRIANGLE, 0, 0, 0, 0, 1023);
        send(MODE_READ, 0);
        send(MODE_READ, 1023);
        send(MODE_TRIANGLE, 0, 0, 0, 0, 1023);
        send(MODE_TRIANGLE, 0, 0, 1023, 0, 0);
        send(MODE_READ, 0);
        send(MODE_READ, 1023);
        send(MODE_CLEAR);
        send(MODE_READ, 0);
        wait_all_done();

        // random segments with varying idle on both sides
        for (int seg = 0; seg < 6; seg++)
        begin
            tx_gap_max = (seg % 3 == 1) ? 0 : 7;
            rx_gap_max = (seg % 2 == 1) ? 0 : 7;
            drain_next = 1'b1;
            for (int i = 0; i < 285; i++)
            begin
                int sel, a, b, c;
                sel = $urandom_range(0, 99);
                if (sel < 20)
                    send(MODE_WRITE, pick_node(), pick_value());
                else if (sel < 70)
                begin
                    a = pick_written();
                    b = pick_written();
                    c = pick_written();
                    case ($urandom_range(0, 9))
                        0: b = a;
                        1: c = a;
                        2: c = b;
                        default: ;
                    endcase
                    send(MODE_TRIANGLE, 0, 0, a, b, c);
                end
                else if (sel < 97)
                    send(MODE_READ, pick_node());
                else
                    send(MODE_CLEAR);
            end
            wait_all_done();
        end

        // drain and let the block settle
        wait_all_done();
        repeat (100) @(posedge clk);
        if (gradient_expect_q.size() != 0)
        begin
            $error("%0d gradient reads never answered", gradient_expect_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
